// ===== sv/rtiq_pkg.sv =====
// Shared types and constants for the real-to-IQ fs/4 half-band down-converter.
package rtiq_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 5;
  localparam int ALPHA_W     = 15;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;
  localparam int ACC_W       = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd32100;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

endpackage

// ===== sv/real_to_iq_fs4_halfband_ddc_core.sv =====
// Real-to-IQ down-converter core: DC removal, fs/4 mixing, half-band I filter and Q delay.
//
// Each input request carries one command. A sample command yields exactly one result: on mix
// phases 0 and 2 the symmetric half-band FIR output (out_tuser 0), on phases 1 and 3 the oldest
// entry of the Q delay line (out_tuser 1). Coefficient writes and clear commands take one input
// slot and give no result. The core takes one request per clock unless the output stalls; a sample
// passes stage 1, the mixing, product and partial-sum registers and the result register. The
// DC-removal recursion (combinational multiply and add) sets this rate; the FIR multipliers, the
// two-level adder tree and the output register are pipelined behind it. A one-entry input skid
// keeps in_tready registered, so a stalled output never blocks the input side combinationally.
// The user must write dc_alpha through the cfg_ port only while idle; the core does not enforce it.
module real_to_iq_fs4_halfband_ddc_core #(
  parameter int COEF_PAIRS    = 21,
  parameter int Q_DELAY_DEPTH = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // sample [15:0], coef_index [20:16], coef_value [36:21], zero [39:37]
  input  logic [rtiq_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd [1:0]
  input  logic [rtiq_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_sample [15:0]
  output logic [rtiq_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_is_q [0]
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtiq_pkg::ALPHA_W-1:0]       cfg_data
);

  localparam int HIST_LEN = 2 * COEF_PAIRS;
  localparam int NGRP     = (COEF_PAIRS + 7) / 8;
  localparam int PADN     = NGRP * 8;

  // Global advance: the whole pipeline moves when the result register can take a new value.
  logic en;
  logic in_acc;

  // Input skid entry
  logic                              skid_v_r;
  logic [rtiq_pkg::CMD_W-1:0]        skid_cmd_r;
  rtiq_pkg::smp_t                    skid_sample_r;
  logic [rtiq_pkg::IDX_W-1:0]        skid_idx_r;
  rtiq_pkg::smp_t                    skid_val_r;

  // Stage 1: registered request
  logic                              p1_v_r;
  logic [rtiq_pkg::CMD_W-1:0]        p1_cmd_r;
  rtiq_pkg::smp_t                    p1_sample_r;
  logic [rtiq_pkg::IDX_W-1:0]        p1_idx_r;
  rtiq_pkg::smp_t                    p1_val_r;

  // Configuration and DC-removal state
  logic [rtiq_pkg::ALPHA_W-1:0]      dc_alpha_r;
  rtiq_pkg::smp_t                    prev_in_r;
  rtiq_pkg::smp_t                    prev_out_r;
  logic                              res_hi_r;
  logic [14:0]                       res_lo_r;
  logic [1:0]                        phase_r;

  // Stage 2: mixed value ready to push
  logic                              p2_v_r;
  logic [rtiq_pkg::CMD_W-1:0]        p2_cmd_r;
  logic                              p2_isq_r;
  rtiq_pkg::smp_t                    p2_push_r;
  logic [rtiq_pkg::IDX_W-1:0]        p2_idx_r;
  rtiq_pkg::smp_t                    p2_val_r;

  // Filter storage
  rtiq_pkg::smp_t                    i_hist_r [HIST_LEN];
  rtiq_pkg::smp_t                    q_dly_r  [Q_DELAY_DEPTH];
  rtiq_pkg::smp_t                    coef_r   [COEF_PAIRS];

  // Stage 3: products
  logic                              p3_v_r;
  logic                              p3_isq_r;
  rtiq_pkg::smp_t                    p3_qval_r;
  logic [rtiq_pkg::ACC_W-1:0]        prod_r [COEF_PAIRS];

  // Stage 4: partial sums
  logic                              p4_v_r;
  logic                              p4_isq_r;
  rtiq_pkg::smp_t                    p4_qval_r;
  logic [rtiq_pkg::ACC_W-1:0]        part_r [NGRP];

  // Result register
  logic                              out_v_r;
  logic                              out_isq_r;
  logic [rtiq_pkg::OUT_DATA_W-1:0]   out_data_r;

  // Combinational signals
  logic signed [31:0]                prod_dc;
  logic [31:0]                       dc_u;
  logic [15:0]                       dc_s;
  logic [15:0]                       dc_y;
  logic [16:0]                       neg_y;
  logic [15:0]                       push_c;
  rtiq_pkg::smp_t                    newh [HIST_LEN];
  logic signed [16:0]                pair_sum [COEF_PAIRS];
  logic signed [31:0]                prod_full [COEF_PAIRS];
  logic [rtiq_pkg::ACC_W-1:0]        prod_pad [PADN];
  logic [rtiq_pkg::ACC_W-1:0]        part_c [NGRP];
  logic [rtiq_pkg::ACC_W-1:0]        acc_c;

  assign en        = !out_v_r || out_tready;
  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_isq_r;

  // ---------------------------------------------------------------- skid and stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      p1_v_r   <= 1'b0;
    end else begin
      if (en) begin
        p1_v_r   <= skid_v_r || in_acc;
        skid_v_r <= 1'b0;
      end else if (in_acc) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_cmd_r    <= in_tuser;
      skid_sample_r <= in_tdata[15:0];
      skid_idx_r    <= in_tdata[20:16];
      skid_val_r    <= in_tdata[36:21];
    end
    if (en) begin
      if (skid_v_r) begin
        p1_cmd_r    <= skid_cmd_r;
        p1_sample_r <= skid_sample_r;
        p1_idx_r    <= skid_idx_r;
        p1_val_r    <= skid_val_r;
      end else begin
        p1_cmd_r    <= in_tuser;
        p1_sample_r <= in_tdata[15:0];
        p1_idx_r    <= in_tdata[20:16];
        p1_val_r    <= in_tdata[36:21];
      end
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_alpha_r <= rtiq_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dc_alpha_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- DC removal and mixing
  // The residue keeps only the fraction lost by the shift and the wrap bit above it.
  assign prod_dc = 32'(prev_out_r) * 32'($signed({1'b0, dc_alpha_r}));
  assign dc_u    = {res_hi_r, 16'b0, res_lo_r} + prod_dc;
  assign dc_s    = dc_u[30:15];
  assign dc_y    = p1_sample_r + dc_s - prev_in_r;
  assign neg_y   = 17'd0 - {dc_y[15], dc_y};

  always_comb begin
    case (phase_r)
      2'd0:    push_c = neg_y[15:0];
      2'd1:    push_c = neg_y[16:1];
      2'd2:    push_c = dc_y;
      default: push_c = {dc_y[15], dc_y[15:1]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r  <= '0;
      prev_out_r <= '0;
      res_hi_r   <= 1'b0;
      res_lo_r   <= '0;
      phase_r    <= '0;
      p2_v_r     <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
      if (p1_v_r) begin
        unique case (p1_cmd_r)
          rtiq_pkg::CMD_SAMPLE: begin
            prev_in_r  <= p1_sample_r;
            prev_out_r <= dc_y;
            res_hi_r   <= dc_u[31] ^ dc_u[30];
            res_lo_r   <= dc_u[14:0];
            phase_r    <= phase_r + 2'd1;
          end
          rtiq_pkg::CMD_CLEAR: begin
            prev_in_r  <= '0;
            prev_out_r <= '0;
            res_hi_r   <= 1'b0;
            res_lo_r   <= '0;
            phase_r    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_cmd_r  <= p1_cmd_r;
      p2_isq_r  <= phase_r[0];
      p2_push_r <= push_c;
      p2_idx_r  <= p1_idx_r;
      p2_val_r  <= p1_val_r;
    end
  end

  // ---------------------------------------------------------------- histories and products
  always_comb begin
    newh[0] = p2_push_r;
    for (int j = 1; j < HIST_LEN; j++) begin
      newh[j] = i_hist_r[j-1];
    end
    for (int k = 0; k < COEF_PAIRS; k++) begin
      pair_sum[k]  = {newh[k][15], newh[k]} + {newh[HIST_LEN-1-k][15], newh[HIST_LEN-1-k]};
      prod_full[k] = 32'(coef_r[k]) * 32'(pair_sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < HIST_LEN; j++) i_hist_r[j] <= '0;
      for (int j = 0; j < Q_DELAY_DEPTH; j++) q_dly_r[j] <= '0;
      for (int k = 0; k < COEF_PAIRS; k++) coef_r[k] <= '0;
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r && (p2_cmd_r == rtiq_pkg::CMD_SAMPLE);
      if (p2_v_r) begin
        unique case (p2_cmd_r)
          rtiq_pkg::CMD_SAMPLE: begin
            if (p2_isq_r) begin
              q_dly_r[0] <= p2_push_r;
              for (int j = 1; j < Q_DELAY_DEPTH; j++) q_dly_r[j] <= q_dly_r[j-1];
            end else begin
              for (int j = 0; j < HIST_LEN; j++) i_hist_r[j] <= newh[j];
            end
          end
          rtiq_pkg::CMD_COEF: begin
            // Indexes past the last pair match no entry and are dropped.
            for (int k = 0; k < COEF_PAIRS; k++) begin
              if (p2_idx_r == rtiq_pkg::IDX_W'(k)) coef_r[k] <= p2_val_r;
            end
          end
          rtiq_pkg::CMD_CLEAR: begin
            for (int j = 0; j < HIST_LEN; j++) i_hist_r[j] <= '0;
            for (int j = 0; j < Q_DELAY_DEPTH; j++) q_dly_r[j] <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_isq_r  <= p2_isq_r;
      p3_qval_r <= q_dly_r[Q_DELAY_DEPTH-1];
      for (int k = 0; k < COEF_PAIRS; k++) prod_r[k] <= prod_full[k];
    end
  end

  // ---------------------------------------------------------------- adder tree
  always_comb begin
    for (int i = 0; i < PADN; i++) prod_pad[i] = '0;
    for (int k = 0; k < COEF_PAIRS; k++) prod_pad[k] = prod_r[k];
    for (int g = 0; g < NGRP; g++) begin
      part_c[g] = '0;
      for (int i = 0; i < 8; i++) part_c[g] = part_c[g] + prod_pad[g*8+i];
    end
    acc_c = '0;
    for (int g = 0; g < NGRP; g++) acc_c = acc_c + part_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r  <= p3_v_r;
      out_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_isq_r  <= p3_isq_r;
      p4_qval_r <= p3_qval_r;
      for (int g = 0; g < NGRP; g++) part_r[g] <= part_c[g];
      out_isq_r  <= p4_isq_r;
      out_data_r <= p4_isq_r ? p4_qval_r : acc_c[30:15];
    end
  end

`ifndef ASSERT_OFF
  // The skid entry is only ever filled while the pipeline is held.
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(!en))
    else $error("skid entry filled while the pipeline was advancing");

  // A clear command leaves the DC state and the mixing phase at zero.
  a_clear_dc_state: assert property (@(posedge clk) disable iff (!rst_n)
    en && p1_v_r && p1_cmd_r == rtiq_pkg::CMD_CLEAR |=>
      phase_r == 2'd0 && prev_in_r == '0 && prev_out_r == '0 && res_lo_r == '0 && !res_hi_r)
    else $error("DC state not cleared");

  // Every sample steps the mixing phase by exactly one.
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    en && p1_v_r && p1_cmd_r == rtiq_pkg::CMD_SAMPLE |=> phase_r == $past(phase_r) + 2'd1)
    else $error("mixing phase did not advance by one");

  // Odd phases route to the Q delay line, even phases to the I filter.
  a_iq_routing: assert property (@(posedge clk) disable iff (!rst_n)
    en && p1_v_r && p1_cmd_r == rtiq_pkg::CMD_SAMPLE |=> p2_v_r && p2_isq_r == $past(phase_r[0]))
    else $error("sample routed to the wrong channel");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the real-to-IQ fs/4 half-band down-converter core.
`timescale 1ns / 100ps

module tb;

  localparam int N_PAIRS         = 21;
  localparam int Q_DEPTH         = 21;
  localparam int HIST_LEN        = 2 * N_PAIRS;
  localparam int N_PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 306;
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 5000;

  localparam logic [rtiq_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] PH_I_NEG = 2'd0;
  localparam logic [1:0] PH_Q_NEG = 2'd1;
  localparam logic [1:0] PH_I_POS = 2'd2;
  localparam logic [1:0] PH_Q_POS = 2'd3;

  localparam rtiq_pkg::smp_t SMP_MAX  = 16'sh7FFF;
  localparam rtiq_pkg::smp_t SMP_MIN  = 16'sh8000;
  localparam rtiq_pkg::smp_t SMP_NEG1 = 16'shFFFF;
  localparam rtiq_pkg::smp_t SMP_ZERO = 16'sh0000;

  typedef struct packed {
    rtiq_pkg::smp_t value;
    logic           is_q;
  } iq_result_t;

  typedef struct packed {
    logic [rtiq_pkg::CMD_W-1:0] cmd;
    rtiq_pkg::smp_t             smp;
    logic [rtiq_pkg::IDX_W-1:0] idx;
    rtiq_pkg::smp_t             cval;
    logic                       typed;
    rtiq_pkg::smp_t             exp_value;
    logic                       exp_q;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [rtiq_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [rtiq_pkg::CMD_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [rtiq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                      out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rtiq_pkg::ALPHA_W-1:0]    cfg_data;

  // Predictor state.
  logic [rtiq_pkg::ALPHA_W-1:0] pole;
  rtiq_pkg::smp_t               last_x;
  rtiq_pkg::smp_t               last_y;
  logic [31:0]                  carry;
  logic [1:0]                   mix_ph;
  rtiq_pkg::smp_t               i_hist [HIST_LEN];
  rtiq_pkg::smp_t               q_line [Q_DEPTH];
  rtiq_pkg::smp_t               coef [N_PAIRS];

  iq_result_t iq_pending [$];
  stim_row_t  stim_table [$];

  int             n_fail;
  int             n_i_checked;
  int             n_q_checked;
  int             n_samples;
  int             n_coef_writes;
  int             n_clears;
  int             n_alpha_writes;
  int             burst_left;
  int             idle_cycles;
  rtiq_pkg::smp_t dc_level;
  logic [9:0]     stall_ctr;

  real_to_iq_fs4_halfband_ddc_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [rtiq_pkg::IN_DATA_W-1:0] pack_request(
      rtiq_pkg::smp_t smp, logic [rtiq_pkg::IDX_W-1:0] idx, rtiq_pkg::smp_t cval);
    return {3'b000, cval, idx, smp};
  endfunction

  function automatic void clear_dc_state();
    last_x = '0;
    last_y = '0;
    carry  = '0;
    mix_ph = PH_I_NEG;
    foreach (i_hist[k]) i_hist[k] = '0;
    foreach (q_line[k]) q_line[k] = '0;
  endfunction

  // Half-band output over the I history after the newest value has been shifted in.
  function automatic rtiq_pkg::smp_t fir_after_push(rtiq_pkg::smp_t v);
    logic [31:0] acc;
    acc = '0;
    for (int k = HIST_LEN - 1; k > 0; k--) i_hist[k] = i_hist[k-1];
    i_hist[0] = v;
    for (int k = 0; k < N_PAIRS; k++)
      acc = acc + int'(coef[k]) * (int'(i_hist[k]) + int'(i_hist[HIST_LEN-1-k]));
    return acc[30:15];
  endfunction

  function automatic rtiq_pkg::smp_t q_after_push(rtiq_pkg::smp_t v);
    rtiq_pkg::smp_t oldest;
    oldest = q_line[Q_DEPTH-1];
    for (int k = Q_DEPTH - 1; k > 0; k--) q_line[k] = q_line[k-1];
    q_line[0] = v;
    return oldest;
  endfunction

  // Advances the predicted state by one accepted request and queues its result, if any.
  function automatic void ddc_predict(logic [rtiq_pkg::CMD_W-1:0] cmd,
                                      logic [rtiq_pkg::IN_DATA_W-1:0] data,
                                      logic typed, rtiq_pkg::smp_t typed_value,
                                      logic typed_q);
    rtiq_pkg::smp_t             x;
    rtiq_pkg::smp_t             s;
    rtiq_pkg::smp_t             y;
    logic [rtiq_pkg::IDX_W-1:0] idx;
    logic [31:0]                w;
    logic [31:0]                u;
    logic [31:0]                neg;
    int                         prod;
    iq_result_t                 r;
    x   = data[15:0];
    idx = data[20:16];
    case (cmd)
      rtiq_pkg::CMD_COEF: begin
        if (idx < N_PAIRS) begin
          coef[idx] = data[36:21];
          n_coef_writes++;
        end
      end
      rtiq_pkg::CMD_CLEAR: begin
        clear_dc_state();
        n_clears++;
      end
      rtiq_pkg::CMD_SAMPLE: begin
        w    = int'(x) - int'(last_x);
        prod = int'(last_y) * int'({1'b0, pole});
        u    = carry + prod;
        s    = u[30:15];
        y    = w[15:0] + s;
        // The fraction dropped by the shift is carried into the next sample.
        carry  = u - (int'(s) <<< 15);
        last_x = x;
        last_y = y;
        case (mix_ph)
          PH_I_NEG: begin
            r.value = fir_after_push(SMP_ZERO - y);
            r.is_q  = 1'b0;
          end
          PH_Q_NEG: begin
            // Halving is done on the full-width negation, so -32768 halves to 16384.
            neg     = 32'd0 - int'(y);
            r.value = q_after_push(neg[16:1]);
            r.is_q  = 1'b1;
          end
          PH_I_POS: begin
            r.value = fir_after_push(y);
            r.is_q  = 1'b0;
          end
          default: begin
            r.value = q_after_push(y >>> 1);
            r.is_q  = 1'b1;
          end
        endcase
        mix_ph = mix_ph + 2'd1;
        if (typed) begin
          r.value = typed_value;
          r.is_q  = typed_q;
        end
        iq_pending.push_back(r);
        n_samples++;
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [rtiq_pkg::CMD_W-1:0] cmd,
                              input logic [rtiq_pkg::IN_DATA_W-1:0] data,
                              input logic typed, input rtiq_pkg::smp_t typed_value,
                              input logic typed_q);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ddc_predict(cmd, data, typed, typed_value, typed_q);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds the input off until every expected result has arrived, then lets the pipe drain.
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (iq_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pole(input logic [rtiq_pkg::ALPHA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pole = value;
    n_alpha_writes++;
  endtask

  function automatic rtiq_pkg::smp_t pick_sample();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case (rnd[1:0])
          2'd0: return SMP_MAX;
          2'd1: return SMP_MIN;
          2'd2: return SMP_ZERO;
          default: return SMP_NEG1;
        endcase
      end
      1, 2, 3, 4: return rnd[15:0];
      default: return dc_level + rtiq_pkg::smp_t'(rnd[8:0]) - 16'sd256;
    endcase
  endfunction

  function automatic rtiq_pkg::smp_t pick_coef();
    logic [31:0] rnd;
    rnd = $urandom;
    if (rnd[31]) return rnd[15:0];
    return rtiq_pkg::smp_t'(rnd[12:0]) - 16'sd4096;
  endfunction

  // Receiver: always ready, random stalls, a fixed 3-of-7 pattern, light random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_ctr  <= '0;
    end else begin
      stall_ctr <= stall_ctr + 10'd1;
      case (stall_ctr[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 9) < 7);
        2'd2: out_tready <= ((stall_ctr % 7) < 3);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    iq_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (iq_pending.size() == 0) begin
        $error("result with nothing expected: out_sample %0d out_is_q %0d",
               $signed(out_tdata), out_tuser);
        n_fail++;
      end else begin
        e = iq_pending.pop_front();
        if (out_tdata !== e.value) begin
          $error("out_sample mismatch: expected %0d, actual %0d", e.value, $signed(out_tdata));
          n_fail++;
        end
        if (out_tuser[0] !== e.is_q) begin
          $error("out_is_q mismatch: expected %0d, actual %0d", e.is_q, out_tuser[0]);
          n_fail++;
        end
        if (e.is_q) n_q_checked++;
        else n_i_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [rtiq_pkg::ALPHA_W-1:0] pole_plan [N_PHASES];
    stim_row_t                    row;
    int                           counted;
    int                           pick;
    logic [rtiq_pkg::IDX_W-1:0]   idx;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = rtiq_pkg::CMD_SAMPLE;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    n_fail      = 0;
    n_i_checked = 0;
    n_q_checked = 0;
    n_samples   = 0;
    n_coef_writes  = 0;
    n_clears       = 0;
    n_alpha_writes = 0;
    idle_cycles    = 0;
    burst_left     = $urandom_range(1, 48);
    dc_level       = '0;
    pole           = rtiq_pkg::ALPHA_RESET;
    foreach (coef[k]) coef[k] = '0;
    clear_dc_state();

    // After reset the coefficients and both histories are zero, so the first outputs are zero.
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MAX, 5'd0, SMP_ZERO, 1'b1, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MIN, 5'd31, SMP_NEG1, 1'b1, SMP_ZERO, 1'b1});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_ZERO, 5'd0, SMP_ZERO, 1'b1, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_NEG1, 5'd0, SMP_ZERO, 1'b1, SMP_ZERO, 1'b1});
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_ZERO, 5'd0, SMP_MAX, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_NEG1, 5'd20, SMP_MIN, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_ZERO, 5'd10, 16'sh4000, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_ZERO, 5'd1, SMP_NEG1, 1'b0, SMP_ZERO, 1'b0});
    // Indexes past the last pair must leave the coefficients alone.
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_ZERO, 5'd21, 16'sh04D2, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_COEF, SMP_ZERO, 5'd31, SMP_MIN, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{CMD_RESERVED, SMP_MAX, 5'd31, SMP_NEG1, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MAX, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MIN, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MIN, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MAX, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, 16'sh3039, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO,
                           1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_CLEAR, SMP_NEG1, 5'd31, SMP_NEG1, 1'b0, SMP_ZERO, 1'b0});
    // Right after a clear, -32768 on an I phase is pushed negated, which wraps to itself.
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MIN, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_CLEAR, SMP_ZERO, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    // Here y is -32768 on the negated Q phase, whose half is 16384.
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_ZERO, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MIN, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});
    stim_table.push_back('{rtiq_pkg::CMD_SAMPLE, SMP_MAX, 5'd0, SMP_ZERO, 1'b0, SMP_ZERO, 1'b0});

    pole_plan[0] = 15'd32767;
    pole_plan[1] = 15'd0;
    pole_plan[2] = 15'($urandom);
    pole_plan[3] = 15'd1;
    pole_plan[4] = rtiq_pkg::ALPHA_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[r]) begin
      row = stim_table[r];
      send_request(row.cmd, pack_request(row.smp, row.idx, row.cval),
                   row.typed, row.exp_value, row.exp_q);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_for_idle();
      write_pole(pole_plan[ph]);
      dc_level = rtiq_pkg::smp_t'($urandom_range(0, 8191)) - 16'sd4096;
      // Each setting starts from a full coefficient load with random content.
      for (int k = 0; k < N_PAIRS; k++)
        send_request(rtiq_pkg::CMD_COEF, pack_request(pick_sample(), 5'(k), pick_coef()),
                     1'b0, SMP_ZERO, 1'b0);
      counted = N_PAIRS;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 199);
        if (pick < 186) begin
          send_request(rtiq_pkg::CMD_SAMPLE,
                       pack_request(pick_sample(), 5'($urandom), pick_coef()),
                       1'b0, SMP_ZERO, 1'b0);
          counted++;
        end else if (pick < 196) begin
          idx = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(21, 31))
                                             : 5'($urandom_range(0, 20));
          send_request(rtiq_pkg::CMD_COEF, pack_request(pick_sample(), idx, pick_coef()),
                       1'b0, SMP_ZERO, 1'b0);
          if (idx < N_PAIRS) counted++;
        end else if (pick < 198) begin
          send_request(rtiq_pkg::CMD_CLEAR,
                       pack_request(pick_sample(), 5'($urandom), pick_coef()),
                       1'b0, SMP_ZERO, 1'b0);
          counted++;
        end else begin
          send_request(CMD_RESERVED, pack_request(pick_sample(), 5'($urandom), pick_coef()),
                       1'b0, SMP_ZERO, 1'b0);
        end
      end
    end

    wait_for_idle();

    $display("Run covered %0d samples, %0d coefficient writes and %0d state clears.",
             n_samples, n_coef_writes, n_clears);
    $display("Compared %0d I and %0d Q outputs over %0d DC pole settings, 0 and 32767 included.",
             n_i_checked, n_q_checked, n_alpha_writes + 1);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rtiq_pkg.sv
sv/real_to_iq_fs4_halfband_ddc_core.sv
tb/tb.sv
